/* hdl/sss_pkg.sv */
// Shared types and constants for the SPI slave shift engine.
// Used by the channel interface, the register block, the pipeline and the checker.
`timescale 1ns / 1ps

package sss_pkg;

  localparam int WORD_W                = 32;
  localparam int CNT_W                 = 6;
  localparam int POS_W                 = 5;
  localparam int CFG_ADDR_W            = 5;
  localparam int CFG_DATA_W            = 32;
  localparam int DEFAULT_MAX_WORD_BITS = 32;
  localparam logic [CNT_W-1:0] RESET_WORD_BITS = 6'd8;

  typedef enum logic [2:0] {
    REG_WORD_BITS       = 3'd0,
    REG_CLOCK_IDLE_HIGH = 3'd1,
    REG_SAMPLE_TRAILING = 3'd2,
    REG_LSB_FIRST       = 3'd3,
    REG_LOOPBACK        = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [CNT_W-1:0] word_bits;
    logic             clock_idle_high;
    logic             sample_trailing;
    logic             lsb_first;
    logic             loopback;
  } cfg_t;

  typedef struct packed {
    logic              clk_level;
    logic              mosi_level;
    logic              select_active;
    logic [WORD_W-1:0] next_tx_word;
  } in_item_t;

  typedef struct packed {
    logic              miso_level;
    logic              word_done;
    logic              word_cut_short;
    logic [WORD_W-1:0] rx_word;
  } out_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

endpackage

/* hdl/sss_chan_if.sv */
// Valid/ready channel carrying one payload struct per transfer.
// Payload type is given per instance, normally from sss_pkg.
`timescale 1ns / 1ps

interface sss_chan_if #(
  parameter type payload_t = sss_pkg::in_item_t
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/spi_slave_shift_engine.sv */
// SPI slave shift engine: one pin sample in, one result out per transfer.
// An input transfer passes the input register, then the result register, before its result is valid.
// Throughput: one transfer per cycle while out_chan is not stalled by a low ready.
// Reset (synchronous, rst_n low): shift state and pipeline valids clear,
// word_bits returns to 8 and all mode bits to 0.
// Depends on sss_pkg, sss_chan_if, sss_cfg_regs, sss_in_stage and sss_bit_engine.
`timescale 1ns / 1ps

module spi_slave_shift_engine #(
  parameter int MAX_WORD_BITS = sss_pkg::DEFAULT_MAX_WORD_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sss_chan_if.sink                       in_chan,
  sss_chan_if.source                     out_chan,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [sss_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [sss_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [sss_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  sss_pkg::cfg_t   cfg;
  sss_pkg::stage_t stage;
  logic            advance;

  sss_cfg_regs u_cfg_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  sss_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .advance (advance),
    .stage   (stage)
  );

  sss_bit_engine #(
    .MAX_WORD_BITS (MAX_WORD_BITS)
  ) u_bit_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .stage    (stage),
    .advance  (advance),
    .out_chan (out_chan)
  );

endmodule

/* hdl/sss_cfg_regs.sv */
// APB-style configuration registers for the SPI slave shift engine.
// Depends on sss_pkg for the register map and the config struct.
`timescale 1ns / 1ps

module sss_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [sss_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [sss_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [sss_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready,
  output sss_pkg::cfg_t                    cfg
);

  sss_pkg::cfg_t cfg_r;
  sss_pkg::cfg_t cfg_nxt;
  logic [2:0]    reg_idx;
  logic          wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[sss_pkg::CFG_ADDR_W-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        sss_pkg::REG_WORD_BITS:       cfg_nxt.word_bits = cfg_pwdata[sss_pkg::CNT_W-1:0];
        sss_pkg::REG_CLOCK_IDLE_HIGH: cfg_nxt.clock_idle_high = cfg_pwdata[0];
        sss_pkg::REG_SAMPLE_TRAILING: cfg_nxt.sample_trailing = cfg_pwdata[0];
        sss_pkg::REG_LSB_FIRST:       cfg_nxt.lsb_first = cfg_pwdata[0];
        sss_pkg::REG_LOOPBACK:        cfg_nxt.loopback = cfg_pwdata[0];
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sss_pkg::REG_WORD_BITS:
        cfg_prdata = {{(sss_pkg::CFG_DATA_W-sss_pkg::CNT_W){1'b0}}, cfg_r.word_bits};
      sss_pkg::REG_CLOCK_IDLE_HIGH:
        cfg_prdata = {{(sss_pkg::CFG_DATA_W-1){1'b0}}, cfg_r.clock_idle_high};
      sss_pkg::REG_SAMPLE_TRAILING:
        cfg_prdata = {{(sss_pkg::CFG_DATA_W-1){1'b0}}, cfg_r.sample_trailing};
      sss_pkg::REG_LSB_FIRST:
        cfg_prdata = {{(sss_pkg::CFG_DATA_W-1){1'b0}}, cfg_r.lsb_first};
      sss_pkg::REG_LOOPBACK:
        cfg_prdata = {{(sss_pkg::CFG_DATA_W-1){1'b0}}, cfg_r.loopback};
      default:
        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.word_bits       <= sss_pkg::RESET_WORD_BITS;
      cfg_r.clock_idle_high <= 1'b0;
      cfg_r.sample_trailing <= 1'b0;
      cfg_r.lsb_first       <= 1'b0;
      cfg_r.loopback        <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* hdl/sss_in_stage.sv */
// Input register stage: captures one pin sample per transfer.
// Depends on sss_pkg and sss_chan_if; stalls on the downstream advance signal.
`timescale 1ns / 1ps

module sss_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  sss_chan_if.sink          in_chan,
  input  logic              advance,
  output sss_pkg::stage_t   stage
);

  logic              valid_r;
  logic              valid_nxt;
  sss_pkg::in_item_t item_r;
  logic              take;

  assign in_chan.ready = !valid_r || advance;
  assign take          = in_chan.valid && in_chan.ready;
  assign valid_nxt     = in_chan.ready ? in_chan.valid : valid_r;

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_chan.payload;
    end
  end

endmodule

/* hdl/sss_bit_engine.sv */
// Bit engine: shift state update and result register for one pin sample.
// Depends on sss_pkg and sss_chan_if; fed by sss_in_stage, configured by sss_cfg_regs.
`timescale 1ns / 1ps

module sss_bit_engine #(
  parameter int MAX_WORD_BITS = sss_pkg::DEFAULT_MAX_WORD_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sss_pkg::cfg_t    cfg,
  input  sss_pkg::stage_t  stage,
  output logic             advance,
  sss_chan_if.source       out_chan
);

  localparam logic [sss_pkg::CNT_W-1:0] MAX_BITS = sss_pkg::CNT_W'(MAX_WORD_BITS);

  logic [sss_pkg::CNT_W-1:0]  bit_count_r, bit_count_nxt;
  logic [sss_pkg::WORD_W-1:0] rx_shift_r, rx_shift_nxt;
  logic [sss_pkg::WORD_W-1:0] tx_hold_r, tx_hold_nxt;
  logic                       after_leading_r, after_leading_nxt;
  logic                       word_open_r, word_open_nxt;
  logic                       out_valid_r;
  sss_pkg::out_item_t         out_item_r, out_item_nxt;
  logic [sss_pkg::CNT_W-1:0]  eff_bits;
  logic                       fire;

  function automatic logic [sss_pkg::POS_W-1:0] bit_pos(
    input logic [sss_pkg::CNT_W-1:0] count,
    input logic [sss_pkg::CNT_W-1:0] bits,
    input logic                      lsb
  );
    logic [sss_pkg::CNT_W-1:0] msb_pos;
    msb_pos = bits - 6'd1 - count;
    return lsb ? count[sss_pkg::POS_W-1:0] : msb_pos[sss_pkg::POS_W-1:0];
  endfunction

  assign advance        = !out_valid_r || out_chan.ready;
  assign fire           = stage.valid && advance;
  assign out_chan.valid = out_valid_r;
  assign out_chan.payload = out_item_r;

  always_comb begin
    if (cfg.word_bits == '0) begin
      eff_bits = 6'd1;
    end else if (cfg.word_bits > MAX_BITS) begin
      eff_bits = MAX_BITS;
    end else begin
      eff_bits = cfg.word_bits;
    end
  end

  always_comb begin
    logic [sss_pkg::POS_W-1:0] pos;
    logic                      idle_lvl;
    pos               = '0;
    idle_lvl          = cfg.clock_idle_high;
    bit_count_nxt     = bit_count_r;
    rx_shift_nxt      = rx_shift_r;
    tx_hold_nxt       = tx_hold_r;
    after_leading_nxt = after_leading_r;
    word_open_nxt     = word_open_r;
    out_item_nxt      = '0;
    if (!stage.item.select_active) begin
      if (word_open_r && (bit_count_r != '0 || after_leading_r)) begin
        out_item_nxt.word_done      = 1'b1;
        out_item_nxt.word_cut_short = 1'b1;
        out_item_nxt.rx_word        = rx_shift_r;
      end
      rx_shift_nxt      = '0;
      bit_count_nxt     = '0;
      after_leading_nxt = 1'b0;
      word_open_nxt     = 1'b0;
    end else begin
      if (!word_open_r) begin
        tx_hold_nxt       = stage.item.next_tx_word;
        rx_shift_nxt      = '0;
        bit_count_nxt     = '0;
        after_leading_nxt = 1'b0;
        word_open_nxt     = 1'b1;
      end
      pos = bit_pos(bit_count_nxt, eff_bits, cfg.lsb_first);
      if (!after_leading_nxt) begin
        if (stage.item.clk_level != idle_lvl) begin
          after_leading_nxt = 1'b1;
          if (!cfg.loopback && !cfg.sample_trailing) begin
            rx_shift_nxt[pos] = rx_shift_nxt[pos] | stage.item.mosi_level;
          end
        end
      end else if (stage.item.clk_level == idle_lvl) begin
        if (cfg.loopback) begin
          rx_shift_nxt[pos] = rx_shift_nxt[pos] | tx_hold_nxt[pos];
        end else if (cfg.sample_trailing) begin
          rx_shift_nxt[pos] = rx_shift_nxt[pos] | stage.item.mosi_level;
        end
        after_leading_nxt = 1'b0;
        bit_count_nxt     = bit_count_nxt + 6'd1;
        if (bit_count_nxt >= eff_bits) begin
          out_item_nxt.word_done = 1'b1;
          out_item_nxt.rx_word   = rx_shift_nxt;
          tx_hold_nxt            = stage.item.next_tx_word;
          rx_shift_nxt           = '0;
          bit_count_nxt          = '0;
          after_leading_nxt      = 1'b0;
          word_open_nxt          = 1'b1;
        end
      end
      out_item_nxt.miso_level =
        tx_hold_nxt[bit_pos(bit_count_nxt, eff_bits, cfg.lsb_first)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_count_r     <= '0;
      rx_shift_r      <= '0;
      tx_hold_r       <= '0;
      after_leading_r <= 1'b0;
      word_open_r     <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (fire) begin
        bit_count_r     <= bit_count_nxt;
        rx_shift_r      <= rx_shift_nxt;
        tx_hold_r       <= tx_hold_nxt;
        after_leading_r <= after_leading_nxt;
        word_open_r     <= word_open_nxt;
      end
      if (advance) begin
        out_valid_r <= stage.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

/* hdl/sss_checker.sv */
// Port-level checker for the SPI slave shift engine, bound to the top level.
// Depends on sss_pkg for the result struct.
`timescale 1ns / 1ps

module sss_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input sss_pkg::out_item_t out_payload,
  input logic               cfg_pready
);

  a_cut_implies_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.word_cut_short |-> out_payload.word_done)
    else $error("cut-short flag without word_done");

  a_idle_rx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload.word_done |-> out_payload.rx_word == '0)
    else $error("rx_word nonzero without word_done");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("configuration port not ready");

endmodule

bind spi_slave_shift_engine sss_checker u_sss_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_payload (out_chan.payload),
  .cfg_pready  (cfg_pready)
);

/* tb/sv/tb.sv */
// Self-checking bench for spi_slave_shift_engine: drives SPI pin samples, random idling.
// A scoreboard class predicts each result and checks it. Needs sss_pkg and sss_chan_if.
`timescale 1ns / 1ps

module tb;
  import sss_pkg::*;

  class shift_scoreboard;
    cfg_t        cfg;
    bit [5:0]    bit_count;
    bit [31:0]   rx_shift;
    bit [31:0]   tx_hold;
    bit          after_leading;
    bit          word_open;
    out_item_t   expected_outs[$];
    int unsigned errors;

    function new();
      cfg = '0;
      cfg.word_bits = RESET_WORD_BITS;
      bit_count = '0;
      rx_shift = '0;
      tx_hold = '0;
      after_leading = 1'b0;
      word_open = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [31:0] v);
      case (idx)
        REG_WORD_BITS:       cfg.word_bits = v[CNT_W-1:0];
        REG_CLOCK_IDLE_HIGH: cfg.clock_idle_high = v[0];
        REG_SAMPLE_TRAILING: cfg.sample_trailing = v[0];
        REG_LSB_FIRST:       cfg.lsb_first = v[0];
        REG_LOOPBACK:        cfg.loopback = v[0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_bits();
      int unsigned wb;
      wb = 32'(cfg.word_bits);
      if (wb < 1) wb = 1;
      if (wb > DEFAULT_MAX_WORD_BITS) wb = DEFAULT_MAX_WORD_BITS;
      return wb;
    endfunction

    function bit [4:0] bit_pos();
      int unsigned wb;
      wb = eff_bits();
      if (cfg.lsb_first) return bit_count[4:0];
      return 5'(wb - 1 - int'(bit_count));
    endfunction

    function void open_word(bit [31:0] tx);
      tx_hold = tx;
      rx_shift = '0;
      bit_count = '0;
      after_leading = 1'b0;
      word_open = 1'b1;
    endfunction

    function out_item_t shift_engine_step(in_item_t s);
      out_item_t r;
      bit [4:0]  pos;
      r = '0;
      if (!s.select_active) begin
        if (word_open && (bit_count != 0 || after_leading)) begin
          r.word_done = 1'b1;
          r.word_cut_short = 1'b1;
          r.rx_word = rx_shift;
        end
        rx_shift = '0;
        bit_count = '0;
        after_leading = 1'b0;
        word_open = 1'b0;
      end else begin
        if (!word_open) open_word(s.next_tx_word);
        if (!after_leading) begin
          if (s.clk_level != cfg.clock_idle_high) begin
            after_leading = 1'b1;
            if (!cfg.loopback && !cfg.sample_trailing)
              rx_shift = rx_shift | (32'(s.mosi_level) << bit_pos());
          end
        end else if (s.clk_level == cfg.clock_idle_high) begin
          pos = bit_pos();
          if (cfg.loopback)
            rx_shift = rx_shift | (32'(tx_hold[pos]) << pos);
          else if (cfg.sample_trailing)
            rx_shift = rx_shift | (32'(s.mosi_level) << pos);
          after_leading = 1'b0;
          bit_count = bit_count + 6'd1;
          if (bit_count >= eff_bits()) begin
            r.word_done = 1'b1;
            r.rx_word = rx_shift;
            open_word(s.next_tx_word);
          end
        end
        r.miso_level = tx_hold[bit_pos()];
      end
      return r;
    endfunction

    function void note_pin_sample(in_item_t s);
      expected_outs.push_back(shift_engine_step(s));
    endfunction

    function void flag(string msg);
      $display("%0t ns: %s", $time, msg);
      errors++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_outs.size() == 0) begin
        flag($sformatf({"unexpected result: expected none, ",
                        "got miso=%b done=%b cut=%b rx=%h"},
                       got.miso_level, got.word_done, got.word_cut_short, got.rx_word));
        return;
      end
      want = expected_outs.pop_front();
      if (got.miso_level !== want.miso_level || got.word_done !== want.word_done ||
          got.word_cut_short !== want.word_cut_short || got.rx_word !== want.rx_word)
        flag($sformatf({"result mismatch: expected miso=%b done=%b cut=%b rx=%h, ",
                        "got miso=%b done=%b cut=%b rx=%h"},
                       want.miso_level, want.word_done, want.word_cut_short, want.rx_word,
                       got.miso_level, got.word_done, got.word_cut_short, got.rx_word));
    endfunction

    function int unsigned pending();
      return expected_outs.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  sss_chan_if #(.payload_t(in_item_t))  in_if ();
  sss_chan_if #(.payload_t(out_item_t)) out_if ();

  shift_scoreboard score;
  int unsigned     samples_sent;
  int unsigned     in_gap_max;
  int unsigned     out_gap_max;
  bit              long_hold_req;

  spi_slave_shift_engine u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_if),
    .out_chan   (out_if),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic in_item_t pin(logic c, logic m, logic sel, logic [31:0] tx);
    in_item_t s;
    s.clk_level = c;
    s.mosi_level = m;
    s.select_active = sel;
    s.next_tx_word = tx;
    return s;
  endfunction

  task automatic send_pin_sample(input in_item_t s);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.payload = s;
    in_if.valid = 1'b1;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    score.note_pin_sample(s);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (score.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write_reg(cfg_reg_e idx, logic [31:0] v);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = CFG_ADDR_W'(int'(idx) * 4);
    cfg_pwdata = v;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    @(negedge clk);
    score.write_reg(idx, v);
    cfg_pwrite = 1'b0;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (cfg_prdata !== v)
      score.flag($sformatf("register %s readback: expected %h, got %h", idx.name(), v,
                           cfg_prdata));
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic write_config(cfg_t c);
    cfg_write_reg(REG_WORD_BITS, 32'(c.word_bits));
    cfg_write_reg(REG_CLOCK_IDLE_HIGH, 32'(c.clock_idle_high));
    cfg_write_reg(REG_SAMPLE_TRAILING, 32'(c.sample_trailing));
    cfg_write_reg(REG_LSB_FIRST, 32'(c.lsb_first));
    cfg_write_reg(REG_LOOPBACK, 32'(c.loopback));
  endtask

  // Well-formed serial clock bursts with random MOSI and transmit words, optionally ended by dropping select.
  task automatic drive_frame(int unsigned n_bits, bit drop_sel);
    in_item_t s;
    logic     idle;
    idle = score.cfg.clock_idle_high;
    s = pin(idle, 1'b0, 1'b1, '0);
    repeat ($urandom_range(1, 2)) begin
      s.mosi_level = 1'($urandom_range(0, 1));
      s.next_tx_word = $urandom;
      send_pin_sample(s);
    end
    for (int b = 0; b < int'(n_bits); b++) begin
      repeat ($urandom_range(1, 3)) begin
        s.clk_level = ~idle;
        s.mosi_level = 1'($urandom_range(0, 1));
        s.next_tx_word = $urandom;
        send_pin_sample(s);
      end
      repeat ($urandom_range(1, 3)) begin
        s.clk_level = idle;
        s.mosi_level = 1'($urandom_range(0, 1));
        s.next_tx_word = $urandom;
        send_pin_sample(s);
      end
    end
    if (drop_sel) begin
      // sometimes cut after a leading edge only, then drop select
      if ($urandom_range(0, 3) == 0)
        send_pin_sample(pin(~idle, 1'($urandom_range(0, 1)), 1'b1, $urandom));
      send_pin_sample(pin(idle, 1'($urandom_range(0, 1)), 1'b0, $urandom));
    end
  endtask

  task automatic drive_noise(int unsigned n);
    repeat (n)
      send_pin_sample(pin(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), $urandom));
  endtask

  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      int unsigned stall;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = 150;
      end else begin
        stall = $urandom_range(0, out_gap_max);
      end
      if (stall != 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready = 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      score.check_result(out_if.payload);
      @(negedge clk);
    end
  end

  initial begin
    #(5_000_000);
    $display("FAIL spi_slave_shift_engine");
    $finish;
  end

  initial begin
    cfg_t        c;
    int unsigned phase_no;
    int unsigned eb;
    int unsigned words;
    int unsigned pick;
    score = new();
    samples_sent = 0;
    in_gap_max = 13;
    out_gap_max = 13;
    long_hold_req = 1'b0;
    phase_no = 0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset settings: 8 bits, MSB first, idle low, sample on leading edge
    send_pin_sample(pin(1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF));
    send_pin_sample(pin(1'b0, 1'b0, 1'b1, 32'hA5A5_A5A5));
    send_pin_sample(pin(1'b1, 1'b1, 1'b1, 32'h0));
    send_pin_sample(pin(1'b0, 1'b0, 1'b1, 32'h0));
    send_pin_sample(pin(1'b1, 1'b0, 1'b1, 32'h0));
    send_pin_sample(pin(1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF));
    send_pin_sample(pin(1'b0, 1'b0, 1'b1, 32'h0));
    send_pin_sample(pin(1'b1, 1'b1, 1'b0, 32'h0));
    for (int b = 0; b < 8; b++) begin
      send_pin_sample(pin(1'b1, 1'($urandom_range(0, 1)), 1'b1, 32'hFFFF_FFFF));
      send_pin_sample(pin(1'b0, 1'($urandom_range(0, 1)), 1'b1, 32'hFFFF_FFFF));
    end
    send_pin_sample(pin(1'b0, 1'b0, 1'b0, 32'h0));

    while (samples_sent < 1875) begin
      wait_drained();
      pick = $urandom_range(0, 9);
      case (pick)
        0: c.word_bits = 6'd0;
        1: c.word_bits = 6'd1;
        2: c.word_bits = 6'd32;
        3: c.word_bits = 6'd63;
        4: c.word_bits = 6'($urandom_range(33, 62));
        5: c.word_bits = 6'd8;
        default: c.word_bits = 6'($urandom_range(2, 12));
      endcase
      c.clock_idle_high = 1'($urandom_range(0, 1));
      c.sample_trailing = 1'($urandom_range(0, 1));
      c.lsb_first = 1'($urandom_range(0, 1));
      c.loopback = 1'($urandom_range(0, 1));
      write_config(c);
      eb = score.eff_bits();
      in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
      if (phase_no == 3) begin
        // hold the receiver off while samples keep coming
        in_gap_max = 0;
        long_hold_req = 1'b1;
      end
      repeat ($urandom_range(2, 5)) begin
        if ($urandom_range(0, 9) < 7) begin
          words = (eb > 16) ? $urandom_range(1, 2) : $urandom_range(1, 3);
          drive_frame(eb * words + (($urandom_range(0, 2) == 0) ? $urandom_range(0, eb) : 0),
                      $urandom_range(0, 4) != 0);
        end else begin
          drive_noise($urandom_range(1, 6));
        end
        if (phase_no == 5) wait_drained();
      end
      phase_no++;
    end

    in_if.valid = 1'b0;
    while (score.pending() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (score.errors == 0) begin
      $display("PASS spi_slave_shift_engine");
    end else begin
      $display("FAIL spi_slave_shift_engine");
    end
    $finish;
  end
endmodule

/* sim.f */
hdl/sss_pkg.sv
hdl/sss_chan_if.sv
hdl/sss_cfg_regs.sv
hdl/sss_in_stage.sv
hdl/sss_bit_engine.sv
hdl/spi_slave_shift_engine.sv
hdl/sss_checker.sv
tb/sv/tb.sv
